>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Priority queue shared definitions
// Default sizes, operation codes and the control bundle that the queue
// drives into every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int KEY_WIDTH_DEF     = 32;
	localparam int PAYLOAD_WIDTH_DEF = 16;

	localparam int FUNC_WIDTH = 2;

	// Operation selector of a request.
	typedef enum logic [FUNC_WIDTH-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_PEEK   = 2'd2
	} func_t;

	// Per-cycle command broadcast along the cell chain.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue storage cell
// Holds one entry of the sorted list. On an insert it keeps its entry,
// takes the new one or takes its upper neighbor's entry; on a pop it takes
// its lower neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int KEY_WIDTH     = spq_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                     clk,
	input  spq_pkg::cell_ctrl_t      ctrl,
	input  logic [KEY_WIDTH-1:0]     new_key,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic                     occupied,
	input  logic                     prev_stays,
	input  logic [KEY_WIDTH-1:0]     prev_key,
	input  logic [PAYLOAD_WIDTH-1:0] prev_payload,
	input  logic [KEY_WIDTH-1:0]     next_key,
	input  logic [PAYLOAD_WIDTH-1:0] next_payload,
	output logic                     stays,
	output logic [KEY_WIDTH-1:0]     key,
	output logic [PAYLOAD_WIDTH-1:0] payload
);

	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;

	// An entry that is greater than or equal to the new key stays ahead of it,
	// which keeps equal keys in arrival order.
	assign stays   = occupied && (key_q >= new_key);
	assign key     = key_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !stays) begin
			if (prev_stays) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end
		end else if (ctrl.pop) begin
			key_q     <= next_key;
			payload_q <= next_payload;
		end
	end

endmodule

>>> rtl/core/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue takes one request per clock cycle and returns one result per
// request, registered in the cycle after acceptance; every cell compares its
// own key with the incoming key in parallel, so insert, get and peek all
// complete on acceptance and the output register only stalls intake
// while a result waits and the consumer is not ready.
module stable_priority_queue_top #(
	parameter int DEPTH         = spq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH     = spq_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
	localparam int COUNT_WIDTH  = $clog2(DEPTH + 1),
	localparam int IN_WIDTH     = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8,
	localparam int OUT_FIELDS   = 2 + KEY_WIDTH + PAYLOAD_WIDTH + COUNT_WIDTH,
	localparam int OUT_WIDTH    = ((OUT_FIELDS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_WIDTH-1:0]              s_tdata,  // key, payload
	input  logic [spq_pkg::FUNC_WIDTH-1:0]   s_tuser,  // func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_WIDTH-1:0]             m_tdata   // valid_res, head_key,
	                                                   // head_payload, overflow, count
);

	logic                     accept;
	logic [KEY_WIDTH-1:0]     in_key;
	logic [PAYLOAD_WIDTH-1:0] in_payload;
	spq_pkg::func_t           in_func;

	logic [COUNT_WIDTH-1:0]   count_q;
	logic [COUNT_WIDTH-1:0]   count_d;
	logic                     m_valid_q;
	logic [OUT_FIELDS-1:0]    result_q;
	logic [OUT_FIELDS-1:0]    result_d;

	logic                     full;
	logic                     empty;
	spq_pkg::cell_ctrl_t      ctrl;

	logic [DEPTH-1:0]         cell_stays;
	logic [KEY_WIDTH-1:0]     cell_key     [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];

	assign in_key     = s_tdata[KEY_WIDTH-1:0];
	assign in_payload = s_tdata[KEY_WIDTH+PAYLOAD_WIDTH-1:KEY_WIDTH];
	assign in_func    = spq_pkg::func_t'(s_tuser);

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full  = (count_q == COUNT_WIDTH'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl     = '0;
		count_d  = count_q;
		result_d = '0;
		unique case (in_func)
			spq_pkg::FUNC_INSERT: begin
				if (full) begin
					result_d[1 + KEY_WIDTH + PAYLOAD_WIDTH] = 1'b1;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + COUNT_WIDTH'(1);
				end
			end
			spq_pkg::FUNC_GET, spq_pkg::FUNC_PEEK: begin
				if (!empty) begin
					result_d[0]                                        = 1'b1;
					result_d[KEY_WIDTH:1]                              = cell_key[0];
					result_d[KEY_WIDTH+PAYLOAD_WIDTH:KEY_WIDTH+1]      = cell_payload[0];
					if (in_func == spq_pkg::FUNC_GET) begin
						ctrl.pop = accept;
						count_d  = count_q - COUNT_WIDTH'(1);
					end
				end
			end
			default: begin
			end
		endcase
		result_d[OUT_FIELDS-1:OUT_FIELDS-COUNT_WIDTH] = count_d;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                     prev_stays;
			logic [KEY_WIDTH-1:0]     prev_key;
			logic [PAYLOAD_WIDTH-1:0] prev_payload;
			logic [KEY_WIDTH-1:0]     next_key;
			logic [PAYLOAD_WIDTH-1:0] next_payload;
			logic                     occupied;

			assign occupied = (COUNT_WIDTH'(gi) < count_q);

			if (gi == 0) begin : g_first
				// The head cell takes the new entry whenever it does not keep its own.
				assign prev_stays   = 1'b1;
				assign prev_key     = '0;
				assign prev_payload = '0;
			end else begin : g_inner
				assign prev_stays   = cell_stays[gi-1];
				assign prev_key     = cell_key[gi-1];
				assign prev_payload = cell_payload[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign next_key     = '0;
				assign next_payload = '0;
			end else begin : g_more
				assign next_key     = cell_key[gi+1];
				assign next_payload = cell_payload[gi+1];
			end

			spq_cell #(
				.KEY_WIDTH     (KEY_WIDTH),
				.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.new_key      (in_key),
				.new_payload  (in_payload),
				.occupied     (occupied),
				.prev_stays   (prev_stays),
				.prev_key     (prev_key),
				.prev_payload (prev_payload),
				.next_key     (next_key),
				.next_payload (next_payload),
				.stays        (cell_stays[gi]),
				.key          (cell_key[gi]),
				.payload      (cell_payload[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_WIDTH'(result_q);

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_WIDTH'(DEPTH))
		else $error("entry count exceeds queue depth");

	a_full_insert_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == spq_pkg::FUNC_INSERT && full)
		|=> (m_tvalid && m_tdata[1 + KEY_WIDTH + PAYLOAD_WIDTH] && $stable(count_q)))
		else $error("insert into a full queue was not dropped and flagged");

	a_get_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == spq_pkg::FUNC_GET && !empty)
		|=> (count_q == $past(count_q) - COUNT_WIDTH'(1)))
		else $error("get on a non-empty queue did not remove the head");

	a_valid_excludes_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1 + KEY_WIDTH + PAYLOAD_WIDTH]))
		else $error("result reports both a head entry and an overflow");
`endif

endmodule
